[src/csu_pkg.sv]
// ----------------------------------------------------------------------------
// csu_pkg
// Shared widths, command/status types and multiplier operand codes for the
// cosine similarity unit.
// ----------------------------------------------------------------------------
package csu_pkg;

    localparam int ELEM_BITS_DEF = 16;
    localparam int DOT_BITS      = 42;
    localparam int NORM_BITS     = 41;
    localparam int SUM_BITS      = 50;
    localparam int MAG_BITS      = 42;
    localparam int HALF_BITS     = 21;
    localparam int MUL_P_BITS    = 63;
    localparam int NPROD_BITS    = 82;
    localparam int RSQ_BITS      = 84;
    localparam int WIDE_BITS     = 116;
    localparam int Q_BITS        = 16;
    localparam int SIM_BITS      = 16;
    localparam int CNT_BITS      = 4;
    localparam int ALIGN_SHIFT   = 30;

    typedef enum logic [1:0] {
        MUL_NB_LO = 2'd0,
        MUL_NB_HI = 2'd1,
        MUL_MG_LO = 2'd2,
        MUL_MG_HI = 2'd3
    } mul_sel_t;

    typedef struct packed {
        logic     capture;
        logic     accum;
        logic     snap;
        logic     mul_issue;
        mul_sel_t mul_sel;
        logic     mul_acc;
        logic     srch_init;
        logic     srch_a;
        logic     srch_b;
        logic     load;
    } csu_cmd_t;

    typedef struct packed {
        logic zero_norm;
    } csu_status_t;

endpackage

[src/csu_datapath.sv]
// ----------------------------------------------------------------------------
// csu_datapath
// Element products, saturating accumulators, shared 42x21 multiplier for the
// norm product and squared dot, bit-serial quotient search and result
// register.
// ----------------------------------------------------------------------------
module csu_datapath import csu_pkg::*; #(
    parameter int ELEM_BITS = ELEM_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  csu_cmd_t                    cmd,
    output csu_status_t                 status,
    input  logic signed [ELEM_BITS-1:0] a_elem,
    input  logic signed [ELEM_BITS-1:0] b_elem,
    output logic signed [SIM_BITS-1:0]  similarity,
    output logic                        zero_norm
);

    localparam int PROD_BITS = 2 * ELEM_BITS;

    localparam logic signed [SUM_BITS-1:0] DOT_MAX =
        SUM_BITS'((64'd1 << (DOT_BITS - 1)) - 64'd1);
    localparam logic signed [SUM_BITS-1:0] DOT_MIN = -DOT_MAX - SUM_BITS'(1);
    localparam logic signed [SUM_BITS-1:0] NORM_MAX =
        SUM_BITS'((64'd1 << NORM_BITS) - 64'd1);

    logic signed [PROD_BITS-1:0] prod_ab_reg, prod_aa_reg, prod_bb_reg;
    logic signed [DOT_BITS-1:0]  dot_acc_reg, dot_acc_next;
    logic        [NORM_BITS-1:0] norm_a_acc_reg, norm_a_acc_next;
    logic        [NORM_BITS-1:0] norm_b_acc_reg, norm_b_acc_next;
    logic signed [SUM_BITS-1:0]  dot_sum, na_sum, nb_sum;

    logic [MAG_BITS-1:0]   mag_reg;
    logic                  neg_reg;
    logic                  zero_reg;
    logic [MAG_BITS-1:0]   mul_x;
    logic [HALF_BITS-1:0]  mul_y;
    logic [MUL_P_BITS-1:0] mprod_reg;
    mul_sel_t              mprod_sel_reg;
    logic [NPROD_BITS-1:0] nprod_reg;
    logic [RSQ_BITS-1:0]   rsq_reg;

    logic [WIDE_BITS-1:0]  q2p_reg, s_reg, d_reg, part_reg, trial, bound;
    logic [Q_BITS-1:0]     q_reg, bit_reg;
    logic                  take;

    logic signed [SIM_BITS-1:0] similarity_reg;
    logic                       zero_norm_reg;

    assign status.zero_norm = (norm_a_acc_reg == '0) || (norm_b_acc_reg == '0);

    always_comb begin
        dot_sum = SUM_BITS'(dot_acc_reg) + SUM_BITS'(prod_ab_reg);
        na_sum  = SUM_BITS'({1'b0, norm_a_acc_reg}) + SUM_BITS'(prod_aa_reg);
        nb_sum  = SUM_BITS'({1'b0, norm_b_acc_reg}) + SUM_BITS'(prod_bb_reg);
        dot_acc_next    = dot_acc_reg;
        norm_a_acc_next = norm_a_acc_reg;
        norm_b_acc_next = norm_b_acc_reg;
        if (cmd.load) begin
            dot_acc_next    = '0;
            norm_a_acc_next = '0;
            norm_b_acc_next = '0;
        end else if (cmd.accum) begin
            if (dot_sum > DOT_MAX) begin
                dot_acc_next = DOT_BITS'(DOT_MAX);
            end else if (dot_sum < DOT_MIN) begin
                dot_acc_next = DOT_BITS'(DOT_MIN);
            end else begin
                dot_acc_next = DOT_BITS'(dot_sum);
            end
            norm_a_acc_next = (na_sum > NORM_MAX) ? NORM_BITS'(NORM_MAX) : NORM_BITS'(na_sum);
            norm_b_acc_next = (nb_sum > NORM_MAX) ? NORM_BITS'(NORM_MAX) : NORM_BITS'(nb_sum);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dot_acc_reg    <= '0;
            norm_a_acc_reg <= '0;
            norm_b_acc_reg <= '0;
        end else begin
            dot_acc_reg    <= dot_acc_next;
            norm_a_acc_reg <= norm_a_acc_next;
            norm_b_acc_reg <= norm_b_acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            prod_ab_reg <= a_elem * b_elem;
            prod_aa_reg <= a_elem * a_elem;
            prod_bb_reg <= b_elem * b_elem;
        end
    end

    always_comb begin
        mul_x = MAG_BITS'(norm_a_acc_reg);
        mul_y = norm_b_acc_reg[HALF_BITS-1:0];
        case (cmd.mul_sel)
            MUL_NB_LO: begin
                mul_x = MAG_BITS'(norm_a_acc_reg);
                mul_y = norm_b_acc_reg[HALF_BITS-1:0];
            end
            MUL_NB_HI: begin
                mul_x = MAG_BITS'(norm_a_acc_reg);
                mul_y = HALF_BITS'(norm_b_acc_reg[NORM_BITS-1:HALF_BITS]);
            end
            MUL_MG_LO: begin
                mul_x = mag_reg;
                mul_y = mag_reg[HALF_BITS-1:0];
            end
            MUL_MG_HI: begin
                mul_x = mag_reg;
                mul_y = HALF_BITS'(mag_reg[MAG_BITS-1:HALF_BITS]);
            end
            default: begin
                mul_x = MAG_BITS'(norm_a_acc_reg);
                mul_y = norm_b_acc_reg[HALF_BITS-1:0];
            end
        endcase
    end

    always_comb begin
        trial = part_reg + d_reg;
        bound = WIDE_BITS'(rsq_reg) << ALIGN_SHIFT;
        take  = (trial <= bound) && !q_reg[Q_BITS-1];
    end

    always_ff @(posedge aclk) begin
        if (cmd.snap) begin
            mag_reg  <= dot_acc_reg[DOT_BITS-1] ? MAG_BITS'(-dot_acc_reg)
                                                : MAG_BITS'(dot_acc_reg);
            neg_reg  <= dot_acc_reg[DOT_BITS-1];
            zero_reg <= status.zero_norm;
        end
        if (cmd.mul_issue) begin
            mprod_reg     <= MUL_P_BITS'(mul_x) * MUL_P_BITS'(mul_y);
            mprod_sel_reg <= cmd.mul_sel;
        end
        if (cmd.mul_acc) begin
            case (mprod_sel_reg)
                MUL_NB_LO: nprod_reg <= NPROD_BITS'(mprod_reg);
                MUL_NB_HI: nprod_reg <= nprod_reg + (NPROD_BITS'(mprod_reg) << HALF_BITS);
                MUL_MG_LO: rsq_reg   <= RSQ_BITS'(mprod_reg);
                MUL_MG_HI: rsq_reg   <= rsq_reg + (RSQ_BITS'(mprod_reg) << HALF_BITS);
                default:   nprod_reg <= nprod_reg;
            endcase
        end
        if (cmd.srch_init) begin
            q_reg   <= '0;
            bit_reg <= Q_BITS'(1) << (Q_BITS - 1);
            q2p_reg <= '0;
            s_reg   <= '0;
            d_reg   <= WIDE_BITS'(nprod_reg) << ALIGN_SHIFT;
        end
        if (cmd.srch_a) begin
            part_reg <= q2p_reg + s_reg;
        end
        if (cmd.srch_b) begin
            if (take) begin
                q_reg   <= q_reg | bit_reg;
                q2p_reg <= trial;
                s_reg   <= (s_reg >> 1) + d_reg;
            end else begin
                s_reg   <= s_reg >> 1;
            end
            d_reg   <= d_reg >> 2;
            bit_reg <= bit_reg >> 1;
        end
        if (cmd.load) begin
            zero_norm_reg <= zero_reg;
            if (zero_reg) begin
                similarity_reg <= '0;
            end else if (neg_reg) begin
                similarity_reg <= SIM_BITS'(Q_BITS'(0) - q_reg);
            end else if (q_reg[Q_BITS-1]) begin
                similarity_reg <= SIM_BITS'({1'b0, {(SIM_BITS-1){1'b1}}});
            end else begin
                similarity_reg <= SIM_BITS'(q_reg);
            end
        end
    end

    assign similarity = similarity_reg;
    assign zero_norm  = zero_norm_reg;

endmodule

[src/csu_ctrl.sv]
// ----------------------------------------------------------------------------
// csu_ctrl
// Sequencer: streams pairs into the accumulators, then walks the norm
// product, the squared dot and the sixteen quotient steps unless a norm is
// zero, and owns the result valid.
// ----------------------------------------------------------------------------
module csu_ctrl import csu_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_last,
    output logic        m_valid,
    input  logic        m_ready,
    output csu_cmd_t    cmd,
    input  csu_status_t status
);

    localparam logic [CNT_BITS-1:0] MUL_LAST  = CNT_BITS'(4);
    localparam logic [CNT_BITS-1:0] SRCH_LAST = CNT_BITS'(Q_BITS - 1);

    typedef enum logic [6:0] {
        ST_RUN    = 7'b0000001,
        ST_DRAIN  = 7'b0000010,
        ST_CHECK  = 7'b0000100,
        ST_MUL    = 7'b0001000,
        ST_SRCH_A = 7'b0010000,
        ST_SRCH_B = 7'b0100000,
        ST_LOAD   = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                pipe_reg, pipe_next;
    logic                m_valid_reg, m_valid_next;
    logic                out_free;

    assign s_ready  = (state_reg == ST_RUN);
    assign m_valid  = m_valid_reg;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        cmd.mul_sel  = mul_sel_t'(cnt_reg[1:0]);
        cmd.capture  = s_valid && s_ready;
        cmd.accum    = pipe_reg;
        pipe_next    = cmd.capture;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_RUN: begin
                if (cmd.capture && s_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                cmd.snap = 1'b1;
                cnt_next = '0;
                state_next = status.zero_norm ? ST_LOAD : ST_MUL;
            end
            ST_MUL: begin
                cmd.mul_issue = !cnt_reg[2];
                cmd.mul_acc   = (cnt_reg != '0);
                cnt_next      = cnt_reg + CNT_BITS'(1);
                if (cnt_reg == MUL_LAST) begin
                    cmd.srch_init = 1'b1;
                    cnt_next      = '0;
                    state_next    = ST_SRCH_A;
                end
            end
            ST_SRCH_A: begin
                cmd.srch_a = 1'b1;
                state_next = ST_SRCH_B;
            end
            ST_SRCH_B: begin
                cmd.srch_b = 1'b1;
                cnt_next   = cnt_reg + CNT_BITS'(1);
                state_next = (cnt_reg == SRCH_LAST) ? ST_LOAD : ST_SRCH_A;
            end
            ST_LOAD: begin
                if (out_free) begin
                    cmd.load     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_RUN;
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_RUN;
            cnt_reg     <= '0;
            pipe_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            pipe_reg    <= pipe_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

[src/cosine_similarity_unit.sv]
// ----------------------------------------------------------------------------
// cosine_similarity_unit
// Streaming cosine similarity of two Q1.15 vectors, one element pair a beat,
// result in Q1.15 truncated toward zero.
//
//   channel  dir  handshake           payload
//   s_       in   s_valid / s_ready   s_a_elem, s_b_elem, s_last
//   m_       out  m_valid / m_ready   m_similarity, m_zero_norm
//
// Pairs are taken one a cycle into the accumulators. After the last beat the
// input stalls through drain and check, the shared 42x21 multiplier forming
// the norm product and squared dot, a two-state step (SRCH_A, SRCH_B) per
// quotient bit over 16 bits, and the result load. With a zero norm only
// drain, check and load run. Reset is synchronous, active low, and clears the
// accumulators. A result held by m_ready low stalls only the next load.
// ----------------------------------------------------------------------------
module cosine_similarity_unit import csu_pkg::*; #(
    parameter int ELEM_BITS = ELEM_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [ELEM_BITS-1:0] s_a_elem,
    input  logic signed [ELEM_BITS-1:0] s_b_elem,
    input  logic                        s_last,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [SIM_BITS-1:0]  m_similarity,
    output logic                        m_zero_norm
);

    csu_cmd_t    cmd;
    csu_status_t status;

    csu_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_last  (s_last),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    csu_datapath #(
        .ELEM_BITS (ELEM_BITS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .a_elem     (s_a_elem),
        .b_elem     (s_b_elem),
        .similarity (m_similarity),
        .zero_norm  (m_zero_norm)
    );

endmodule
